@@ rtl/scpb_pkg.sv @@
// Package for the sparse column pattern builder.
// Holds field widths, storage defaults, operation and status codes.
// No dependencies.
package scpb_pkg;

   // default storage sizes
   localparam int MAX_EQ_DEF  = 1024;
   localparam int MAX_NNZ_DEF = 16384;

   // item field widths
   localparam int OP_W     = 3;
   localparam int EQNO_W   = 11;
   localparam int AMOUNT_W = 7;
   localparam int INDEX_W  = 15;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 15;
   localparam int TOTAL_W  = 15;
   localparam int NUMEQ_W  = 11;

   typedef enum logic [OP_W-1:0] {
      OP_RESERVE    = 3'd0,
      OP_BEGIN      = 3'd1,
      OP_INSERT     = 3'd2,
      OP_COMPRESS   = 3'd3,
      OP_READ_START = 3'd4,
      OP_READ_ROW   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_INACTIVE = 3'd1,
      ST_PRESENT  = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_RANGE    = 3'd4
   } status_type;

endpackage

@@ rtl/scpb_channels.sv @@
// Valid/ready channel interfaces of the sparse column pattern builder.
// Depends on scpb_pkg for the payload widths.
interface scpb_req_if;
   logic                             valid;
   logic                             ready;
   logic [scpb_pkg::OP_W-1:0]        op;
   logic [scpb_pkg::EQNO_W-1:0]      col_eqno;
   logic [scpb_pkg::EQNO_W-1:0]      row_eqno;
   logic [scpb_pkg::AMOUNT_W-1:0]    amount;
   logic [scpb_pkg::INDEX_W-1:0]     index;
   modport source (output valid, op, col_eqno, row_eqno, amount, index, input ready);
   modport sink   (input valid, op, col_eqno, row_eqno, amount, index, output ready);
endinterface

interface scpb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [scpb_pkg::STATUS_W-1:0]    status;
   logic [scpb_pkg::VALUE_W-1:0]     read_value;
   logic [scpb_pkg::TOTAL_W-1:0]     entry_total;
   modport source (output valid, status, read_value, entry_total, input ready);
   modport sink   (input valid, status, read_value, entry_total, output ready);
endinterface

interface scpb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [scpb_pkg::NUMEQ_W-1:0]     data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/scpb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/sparse_column_pattern_builder.sv @@
// Sparse column pattern builder: one item at a time, one result per item.
// A new item is taken only after the last result has gone to the output register; walks share one port.
// Reset (synchronous, active high) starts a clearing pass over the column RAMs; no item
// is taken meanwhile, configuration writes are.
// Depends on scpb_pkg, scpb_channels and scpb_ram.
module sparse_column_pattern_builder #(
   parameter int MAX_EQ  = scpb_pkg::MAX_EQ_DEF,
   parameter int MAX_NNZ = scpb_pkg::MAX_NNZ_DEF
) (
   input  logic        clock,
   input  logic        reset,
   scpb_req_if.sink    req_ch,
   scpb_rsp_if.source  rsp_ch,
   scpb_csr_if.sink    csr_ch
);

   localparam int CI_W = $clog2(MAX_EQ);       // column index
   localparam int CS_W = $clog2(MAX_EQ + 1);   // column start address, dimension
   localparam int RI_W = $clog2(MAX_NNZ);      // row store address
   localparam int P_W  = $clog2(MAX_NNZ + 1);  // positions and counts
   localparam int W_W  = P_W + 1;              // compress write pointer
   localparam int RV_W = scpb_pkg::VALUE_W;
   localparam int RT_W = scpb_pkg::TOTAL_W;
   localparam logic [31:0] MAX_EQ_U  = 32'(MAX_EQ);
   localparam logic [31:0] MAX_NNZ_U = 32'(MAX_NNZ);

   typedef enum logic [4:0] {
      S_IDLE, S_RES_WR, S_BEG_RD, S_BEG_WR, S_INS_RD1, S_INS_CAP, S_WALK_RD,
      S_WALK_CMP, S_INS_CHK, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR, S_CMP_RD, S_CMP_CAP,
      S_COPY_RD, S_COPY_WR, S_CMP_END, S_RD_WAIT, S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic                          clr_ff, clr_in;
   logic [scpb_pkg::OP_W-1:0]     op_ff, op_in;
   logic [scpb_pkg::EQNO_W-1:0]   col_ff, col_in;
   logic [scpb_pkg::EQNO_W-1:0]   row_ff, row_in;
   logic [scpb_pkg::AMOUNT_W-1:0] amount_ff, amount_in;
   logic [CS_W-1:0]               i_ff, i_in;
   logic [P_W-1:0]                acc_ff, acc_in;
   logic [P_W-1:0]                base_ff, base_in;
   logic [P_W-1:0]                len_ff, len_in;
   logic [P_W-1:0]                cap_ff, cap_in;
   logic [P_W-1:0]                j_ff, j_in;
   logic [P_W-1:0]                k_ff, k_in;
   logic [W_W-1:0]                wr_ff, wr_in;
   logic [W_W-1:0]                start_ff, start_in;
   logic [P_W-1:0]                from_ff, from_in;
   logic [P_W-1:0]                clen_ff, clen_in;
   logic                          ok_ff, ok_in;
   scpb_pkg::status_type          status_ff, status_in;
   logic [RV_W-1:0]               val_ff, val_in;
   logic [P_W-1:0]                est_total_ff, est_total_in;
   logic [P_W-1:0]                entry_cnt_ff, entry_cnt_in;
   logic [scpb_pkg::NUMEQ_W-1:0]  num_eq_ff, num_eq_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   scpb_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [RV_W-1:0]               rsp_val_ff, rsp_val_in;
   logic [RT_W-1:0]               rsp_tot_ff, rsp_tot_in;

   // RAM ports
   logic            est_we, est_re, len_we, len_re, cs_we, cs_re, rs_we, rs_re;
   logic [CI_W-1:0] est_waddr, est_raddr, len_waddr, len_raddr;
   logic [P_W-1:0]  est_wdata, est_rdata, len_wdata, len_rdata;
   logic [CS_W-1:0] cs_waddr, cs_raddr;
   logic [P_W-1:0]  cs_wdata, cs_rdata;
   logic [RI_W-1:0] rs_waddr, rs_raddr;
   logic [CI_W-1:0] rs_wdata, rs_rdata;

   // working values
   logic [31:0]     n32, numeq32, rc32, rr32, ridx32, rcm1, col32, colm1, rowm1;
   logic [31:0]     add32, sum32, ext32, tot32;
   logic [CS_W-1:0] n;
   logic [P_W:0]    pos_walk, pos_end, pos_shift, pos_shift_m1, src;
   logic [CI_W-1:0] row_idx, walk_v;

   scpb_ram #(.WIDTH(P_W), .DEPTH(MAX_EQ)) u_est_ram (
      .clock(clock), .wr_en(est_we), .wr_addr(est_waddr), .wr_data(est_wdata),
      .rd_en(est_re), .rd_addr(est_raddr), .rd_data(est_rdata));

   scpb_ram #(.WIDTH(P_W), .DEPTH(MAX_EQ)) u_len_ram (
      .clock(clock), .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
      .rd_en(len_re), .rd_addr(len_raddr), .rd_data(len_rdata));

   scpb_ram #(.WIDTH(P_W), .DEPTH(MAX_EQ + 1)) u_start_ram (
      .clock(clock), .wr_en(cs_we), .wr_addr(cs_waddr), .wr_data(cs_wdata),
      .rd_en(cs_re), .rd_addr(cs_raddr), .rd_data(cs_rdata));

   scpb_ram #(.WIDTH(CI_W), .DEPTH(MAX_NNZ)) u_row_ram (
      .clock(clock), .wr_en(rs_we), .wr_addr(rs_waddr), .wr_data(rs_wdata),
      .rd_en(rs_re), .rd_addr(rs_raddr), .rd_data(rs_rdata));

   // dimension in use: 0 acts as 1, clamp at MAX_EQ
   always_comb begin
      numeq32 = 32'(num_eq_ff);
      if (numeq32 == 32'd0) begin
         n32 = 32'd1;
      end else if (numeq32 > MAX_EQ_U) begin
         n32 = MAX_EQ_U;
      end else begin
         n32 = numeq32;
      end
      n = n32[CS_W-1:0];
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.read_value  = rsp_val_ff;
   assign rsp_ch.entry_total = rsp_tot_ff;

   // sequencer next state and RAM controls
   always_comb begin
      state_in = state_ff;   clr_in = clr_ff;       op_in = op_ff;
      col_in = col_ff;       row_in = row_ff;       amount_in = amount_ff;
      i_in = i_ff;           acc_in = acc_ff;       base_in = base_ff;
      len_in = len_ff;       cap_in = cap_ff;       j_in = j_ff;
      k_in = k_ff;           wr_in = wr_ff;         start_in = start_ff;
      from_in = from_ff;     clen_in = clen_ff;     ok_in = ok_ff;
      status_in = status_ff; val_in = val_ff;
      est_total_in = est_total_ff;  entry_cnt_in = entry_cnt_ff;
      num_eq_in = num_eq_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_status_in = rsp_status_ff;
      rsp_val_in = rsp_val_ff;      rsp_tot_in = rsp_tot_ff;

      est_we = 1'b0; est_waddr = '0; est_wdata = '0; est_re = 1'b0; est_raddr = '0;
      len_we = 1'b0; len_waddr = '0; len_wdata = '0; len_re = 1'b0; len_raddr = '0;
      cs_we = 1'b0;  cs_waddr = '0;  cs_wdata = '0;  cs_re = 1'b0;  cs_raddr = '0;
      rs_we = 1'b0;  rs_waddr = '0;  rs_wdata = '0;  rs_re = 1'b0;  rs_raddr = '0;

      rc32   = 32'(req_ch.col_eqno);
      rr32   = 32'(req_ch.row_eqno);
      ridx32 = 32'(req_ch.index);
      rcm1   = rc32 - 32'd1;
      col32  = 32'(col_ff);
      colm1  = col32 - 32'd1;
      rowm1  = 32'(row_ff) - 32'd1;
      row_idx = rowm1[CI_W-1:0];
      pos_walk     = {1'b0, base_ff} + {1'b0, j_ff};
      pos_end      = {1'b0, base_ff} + {1'b0, len_ff};
      pos_shift    = {1'b0, base_ff} + {1'b0, k_ff};
      pos_shift_m1 = pos_shift - 1'b1;
      src          = {1'b0, from_ff} + {1'b0, j_ff};
      walk_v  = ok_ff ? rs_rdata : '0;
      add32 = 32'd0;
      sum32 = 32'd0;
      ext32 = 32'd0;
      tot32 = 32'(entry_cnt_ff);

      // register write
      if (csr_ch.valid) begin
         num_eq_in = csr_ch.data;
      end

      // result taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in = req_ch.op;
               col_in = req_ch.col_eqno;
               row_in = req_ch.row_eqno;
               amount_in = req_ch.amount;
               val_in = '0;
               state_in = S_DONE;
               case (req_ch.op)
                  scpb_pkg::OP_RESERVE: begin
                     if (rc32 == 32'd0) begin
                        status_in = scpb_pkg::ST_INACTIVE;
                     end else if (rc32 > n32) begin
                        status_in = scpb_pkg::ST_RANGE;
                     end else if (32'(est_total_ff) + 32'(req_ch.amount) > MAX_NNZ_U) begin
                        status_in = scpb_pkg::ST_OVERFLOW;
                     end else begin
                        est_re = 1'b1;
                        est_raddr = rcm1[CI_W-1:0];
                        state_in = S_RES_WR;
                     end
                  end
                  scpb_pkg::OP_BEGIN: begin
                     i_in = '0;
                     acc_in = '0;
                     clr_in = 1'b0;
                     state_in = S_BEG_RD;
                  end
                  scpb_pkg::OP_INSERT: begin
                     if (rc32 == 32'd0 || rr32 == 32'd0) begin
                        status_in = scpb_pkg::ST_INACTIVE;
                     end else if (rc32 > n32 || rr32 > n32) begin
                        status_in = scpb_pkg::ST_RANGE;
                     end else begin
                        cs_re = 1'b1;
                        cs_raddr = rcm1[CS_W-1:0];
                        len_re = 1'b1;
                        len_raddr = rcm1[CI_W-1:0];
                        state_in = S_INS_RD1;
                     end
                  end
                  scpb_pkg::OP_COMPRESS: begin
                     i_in = '0;
                     wr_in = '0;
                     state_in = S_CMP_RD;
                  end
                  scpb_pkg::OP_READ_START: begin
                     if (ridx32 > n32) begin
                        status_in = scpb_pkg::ST_RANGE;
                     end else begin
                        cs_re = 1'b1;
                        cs_raddr = ridx32[CS_W-1:0];
                        state_in = S_RD_WAIT;
                     end
                  end
                  scpb_pkg::OP_READ_ROW: begin
                     if (ridx32 >= MAX_NNZ_U) begin
                        status_in = scpb_pkg::ST_RANGE;
                     end else begin
                        rs_re = 1'b1;
                        rs_raddr = ridx32[RI_W-1:0];
                        state_in = S_RD_WAIT;
                     end
                  end
                  default: begin
                     status_in = scpb_pkg::ST_INACTIVE;
                  end
               endcase
            end
         end

         // reserve: add to the column estimate
         S_RES_WR: begin
            sum32 = 32'(est_rdata) + 32'(amount_ff);
            est_we = 1'b1;
            est_waddr = colm1[CI_W-1:0];
            est_wdata = sum32[P_W-1:0];
            add32 = 32'(est_total_ff) + 32'(amount_ff);
            est_total_in = add32[P_W-1:0];
            status_in = scpb_pkg::ST_OK;
            state_in = S_DONE;
         end

         // begin (and clearing pass): running sum of estimates into starts, estimates and lengths cleared
         S_BEG_RD: begin
            est_re = 1'b1;
            est_raddr = i_ff[CI_W-1:0];
            if (i_ff == '0) begin
               cs_we = 1'b1;
               cs_waddr = '0;
               cs_wdata = '0;
            end
            state_in = S_BEG_WR;
         end
         S_BEG_WR: begin
            add32 = (!clr_ff && 32'(i_ff) < n32) ? 32'(est_rdata) : 32'd0;
            sum32 = 32'(acc_ff) + add32;
            cs_we = 1'b1;
            cs_waddr = i_ff + CS_W'(1);
            cs_wdata = sum32[P_W-1:0];
            est_we = 1'b1;
            est_waddr = i_ff[CI_W-1:0];
            est_wdata = '0;
            len_we = 1'b1;
            len_waddr = i_ff[CI_W-1:0];
            len_wdata = '0;
            acc_in = sum32[P_W-1:0];
            if (32'(i_ff) == MAX_EQ_U - 32'd1) begin
               if (clr_ff) begin
                  clr_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  entry_cnt_in = '0;
                  est_total_in = '0;
                  status_in = scpb_pkg::ST_OK;
                  state_in = S_DONE;
               end
            end else begin
               i_in = i_ff + CS_W'(1);
               state_in = S_BEG_RD;
            end
         end

         // insert: fetch base, length, then end of column space
         S_INS_RD1: begin
            base_in = cs_rdata;
            len_in = len_rdata;
            cs_re = 1'b1;
            cs_raddr = col32[CS_W-1:0];
            state_in = S_INS_CAP;
         end
         S_INS_CAP: begin
            cap_in = (cs_rdata >= base_ff) ? (cs_rdata - base_ff) : '0;
            j_in = '0;
            state_in = S_WALK_RD;
         end
         // walk the sorted column
         S_WALK_RD: begin
            if (j_ff < len_ff) begin
               ok_in = (32'(pos_walk) < MAX_NNZ_U);
               rs_re = (32'(pos_walk) < MAX_NNZ_U);
               rs_raddr = pos_walk[RI_W-1:0];
               state_in = S_WALK_CMP;
            end else begin
               state_in = S_INS_CHK;
            end
         end
         S_WALK_CMP: begin
            if (row_idx < walk_v) begin
               state_in = S_INS_CHK;
            end else if (row_idx == walk_v) begin
               status_in = scpb_pkg::ST_PRESENT;
               state_in = S_DONE;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end
         S_INS_CHK: begin
            if (len_ff >= cap_ff || 32'(pos_end) >= MAX_NNZ_U) begin
               status_in = scpb_pkg::ST_OVERFLOW;
               state_in = S_DONE;
            end else begin
               k_in = len_ff;
               state_in = S_SHIFT_RD;
            end
         end
         // open a gap at j, moving entries up from the end
         S_SHIFT_RD: begin
            if (k_ff > j_ff) begin
               rs_re = 1'b1;
               rs_raddr = pos_shift_m1[RI_W-1:0];
               state_in = S_SHIFT_WR;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_SHIFT_WR: begin
            rs_we = 1'b1;
            rs_waddr = pos_shift[RI_W-1:0];
            rs_wdata = rs_rdata;
            k_in = k_ff - 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_INS_WR: begin
            rs_we = 1'b1;
            rs_waddr = pos_walk[RI_W-1:0];
            rs_wdata = row_idx;
            len_we = 1'b1;
            len_waddr = colm1[CI_W-1:0];
            len_wdata = len_ff + 1'b1;
            entry_cnt_in = entry_cnt_ff + 1'b1;
            status_in = scpb_pkg::ST_OK;
            state_in = S_DONE;
         end

         // compress: pack columns in order
         S_CMP_RD: begin
            if (32'(i_ff) < n32) begin
               cs_re = 1'b1;
               cs_raddr = i_ff;
               len_re = 1'b1;
               len_raddr = i_ff[CI_W-1:0];
               state_in = S_CMP_CAP;
            end else begin
               state_in = S_CMP_END;
            end
         end
         S_CMP_CAP: begin
            from_in = cs_rdata;
            clen_in = len_rdata;
            start_in = wr_ff;
            j_in = '0;
            state_in = S_COPY_RD;
         end
         S_COPY_RD: begin
            if (j_ff < clen_ff) begin
               if (32'(src) < MAX_NNZ_U && 32'(wr_ff) < MAX_NNZ_U) begin
                  rs_re = 1'b1;
                  rs_raddr = src[RI_W-1:0];
                  state_in = S_COPY_WR;
               end else begin
                  wr_in = wr_ff + 1'b1;
                  j_in = j_ff + 1'b1;
               end
            end else begin
               cs_we = 1'b1;
               cs_waddr = i_ff;
               cs_wdata = start_ff[P_W-1:0];
               i_in = i_ff + CS_W'(1);
               state_in = S_CMP_RD;
            end
         end
         S_COPY_WR: begin
            rs_we = 1'b1;
            rs_waddr = wr_ff[RI_W-1:0];
            rs_wdata = rs_rdata;
            wr_in = wr_ff + 1'b1;
            j_in = j_ff + 1'b1;
            state_in = S_COPY_RD;
         end
         S_CMP_END: begin
            cs_we = 1'b1;
            cs_waddr = n;
            cs_wdata = wr_ff[P_W-1:0];
            status_in = scpb_pkg::ST_OK;
            state_in = S_DONE;
         end

         // read data back
         S_RD_WAIT: begin
            ext32 = (op_ff == scpb_pkg::OP_READ_START) ? 32'(cs_rdata) : 32'(rs_rdata);
            val_in = ext32[RV_W-1:0];
            status_in = scpb_pkg::ST_OK;
            state_in = S_DONE;
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_val_in = val_ff;
               rsp_tot_in = tot32[RT_W-1:0];
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BEG_RD;
         clr_ff <= 1'b1;
         i_ff <= '0;
         acc_ff <= '0;
         est_total_ff <= '0;
         entry_cnt_ff <= '0;
         num_eq_ff <= scpb_pkg::NUMEQ_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         i_ff <= i_in;
         acc_ff <= acc_in;
         est_total_ff <= est_total_in;
         entry_cnt_ff <= entry_cnt_in;
         num_eq_ff <= num_eq_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff <= op_in;
         col_ff <= col_in;
         row_ff <= row_in;
         amount_ff <= amount_in;
         base_ff <= base_in;
         len_ff <= len_in;
         cap_ff <= cap_in;
         j_ff <= j_in;
         k_ff <= k_in;
         wr_ff <= wr_in;
         start_ff <= start_in;
         from_ff <= from_in;
         clen_ff <= clen_in;
         ok_ff <= ok_in;
         status_ff <= status_in;
         val_ff <= val_in;
         rsp_status_ff <= rsp_status_in;
         rsp_val_ff <= rsp_val_in;
         rsp_tot_ff <= rsp_tot_in;
      end
   end

   // reservations never exceed the row store
   a_est_total: assert property (@(posedge clock) disable iff (reset)
      32'(est_total_ff) <= MAX_NNZ_U)
      else $error("estimate total beyond row store");

   // no item is taken during the clearing pass
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_ch.ready)
      else $error("item accepted while clearing");

   // a result appears only out of the hand-off state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside hand-off");

   // inserted entry lands inside the row store
   a_ins_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_WR |-> 32'(pos_walk) < MAX_NNZ_U)
      else $error("insert position out of row store");

endmodule

@@ verif/scpb_checker.sv @@
// Checker for the sparse column pattern builder: watches the request, result and
// register channels, predicts every result and compares it with what comes out.
// Depends on scpb_pkg and the channel interfaces in scpb_channels.
`timescale 1ns / 100ps

module scpb_checker (
   input  logic   clock,
   input  logic   reset,
   scpb_req_if    req_ch,
   scpb_rsp_if    rsp_ch,
   scpb_csr_if    csr_ch,
   output int     fail_count,
   output int     pending
);
   import scpb_pkg::*;

   localparam int NEQ = MAX_EQ_DEF;
   localparam int NNZ = MAX_NNZ_DEF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [TOTAL_W-1:0]  entry_total;
   } outcome_t;

   outcome_t outcome_q[$];

   // predicted copy of the block's state
   logic [NUMEQ_W-1:0] dim_reg;
   int                 est_len   [NEQ];
   int                 start_of  [NEQ+1];
   int                 len_of    [NEQ];
   logic [9:0]         row_mem   [NNZ];
   bit                 row_written [NNZ];
   int                 nnz_count;
   int                 est_sum;

   function automatic int active_dim();
      if (dim_reg == 0) return 1;
      if (dim_reg > NEQ) return NEQ;
      return int'(dim_reg);
   endfunction

   function automatic void clear_pattern();
      dim_reg   = 1;
      nnz_count = 0;
      est_sum   = 0;
      for (int i = 0; i < NEQ; i++) begin
         est_len[i] = 0;
         len_of[i]  = 0;
      end
      for (int i = 0; i <= NEQ; i++) start_of[i] = 0;
      for (int i = 0; i < NNZ; i++) begin
         row_mem[i]     = '0;
         row_written[i] = 1'b0;
      end
   endfunction

   // sorted insert of row r into column c, both 0-based
   function automatic status_type place_row(int c, int r);
      int base, len, room, j, p, v;
      base = start_of[c];
      len  = len_of[c];
      room = (start_of[c+1] >= base) ? start_of[c+1] - base : 0;
      j    = 0;
      while (j < len) begin
         p = base + j;
         v = (p < NNZ) ? int'(row_mem[p]) : 0;
         if (r < v) break;
         if (r == v) return ST_PRESENT;
         j++;
      end
      if (len >= room || base + len >= NNZ) return ST_OVERFLOW;
      for (int k = len; k > j; k--) begin
         row_mem[base+k]     = row_mem[base+k-1];
         row_written[base+k] = 1'b1;
      end
      row_mem[base+j]     = r[9:0];
      row_written[base+j] = 1'b1;
      len_of[c]           = len + 1;
      nnz_count++;
      return ST_OK;
   endfunction

   function automatic void pack_columns(int n);
      int wr, first, src;
      wr = 0;
      for (int i = 0; i < n; i++) begin
         first = wr;
         for (int j = 0; j < len_of[i]; j++) begin
            src = start_of[i] + j;
            if (src < NNZ && wr < NNZ) begin
               row_mem[wr]     = row_mem[src];
               row_written[wr] = 1'b1;
            end
            wr++;
         end
         start_of[i] = first;
      end
      start_of[n] = wr;
   endfunction

   function automatic outcome_t predict_outcome(logic [OP_W-1:0] op, int col, int row,
                                                int amt, int idx);
      outcome_t   o;
      status_type st;
      int         n, val;
      n   = active_dim();
      st  = ST_OK;
      val = 0;
      case (op)
         OP_RESERVE: begin
            if (col == 0) st = ST_INACTIVE;
            else if (col > n) st = ST_RANGE;
            else if (est_sum + amt > NNZ) st = ST_OVERFLOW;
            else begin
               est_len[col-1] += amt;
               est_sum        += amt;
            end
         end
         OP_BEGIN: begin
            start_of[0] = 0;
            for (int i = 0; i < n; i++) start_of[i+1] = start_of[i] + est_len[i];
            for (int i = n + 1; i <= NEQ; i++) start_of[i] = start_of[n];
            for (int i = 0; i < NEQ; i++) begin
               len_of[i]  = 0;
               est_len[i] = 0;
            end
            nnz_count = 0;
            est_sum   = 0;
         end
         OP_INSERT: begin
            if (col == 0 || row == 0) st = ST_INACTIVE;
            else if (col > n || row > n) st = ST_RANGE;
            else st = place_row(col - 1, row - 1);
         end
         OP_COMPRESS: pack_columns(n);
         OP_READ_START: begin
            if (idx > n) st = ST_RANGE;
            else val = start_of[idx];
         end
         OP_READ_ROW: begin
            if (idx >= NNZ) st = ST_RANGE;
            else val = int'(row_mem[idx]);
         end
         default: st = ST_INACTIVE;
      endcase
      o.status      = st;
      o.read_value  = val[VALUE_W-1:0];
      o.entry_total = nnz_count[TOTAL_W-1:0];
      return o;
   endfunction

   // results are compared before the new item is predicted
   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         clear_pattern();
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
               $error("result with no item outstanding");
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         rsp_ch.read_value);
                  fail_count++;
               end
               if (rsp_ch.entry_total !== want.entry_total) begin
                  $error("entry_total: expected %0d, got %0d", want.entry_total,
                         rsp_ch.entry_total);
                  fail_count++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) dim_reg = csr_ch.data;
         if (req_ch.valid && req_ch.ready)
            outcome_q.push_back(predict_outcome(req_ch.op, int'(req_ch.col_eqno),
                                                int'(req_ch.row_eqno), int'(req_ch.amount),
                                                int'(req_ch.index)));
      end
      pending = outcome_q.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule

@@ verif/tb.sv @@
// Testbench top for the sparse column pattern builder: clock, reset, stimulus
// and verdict. Prediction and comparison sit in scpb_checker.
// Depends on scpb_pkg, scpb_channels, scpb_checker and the block itself.
`timescale 1ns / 100ps

module tb;
   import scpb_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int ITEM_TARGET  = 1050;
   localparam int HOLD_CYCLES  = 600;
   localparam int NNZ          = MAX_NNZ_DEF;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count;
   int   send_idle;
   int   recv_stall;
   int   hold_asks;
   int   hold_done;
   int   items_sent;
   int   cur_dim;

   scpb_req_if req ();
   scpb_rsp_if rsp ();
   scpb_csr_if csr ();

   sparse_column_pattern_builder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   scpb_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req),
      .rsp_ch     (rsp),
      .csr_ch     (csr),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("** sparse_column_pattern_builder: FAILED **");
            $finish;
         end
      end
   end

   // result side: random stalls plus an occasional long hold-off
   initial begin
      int left;
      rsp.ready = 1'b0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            left      = HOLD_CYCLES;
         end
         if (left > 0) begin
            rsp.ready = 1'b0;
            left--;
         end else begin
            rsp.ready = ($urandom_range(99) >= recv_stall);
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [EQNO_W-1:0] col,
                            input logic [EQNO_W-1:0] row, input logic [AMOUNT_W-1:0] amt,
                            input logic [INDEX_W-1:0] idx);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid    = 1'b1;
      req.op       = op;
      req.col_eqno = col;
      req.row_eqno = row;
      req.amount   = amt;
      req.index    = idx;
      do @(posedge clock); while (!req.ready);
      items_sent++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_dim(input logic [NUMEQ_W-1:0] value);
      drain();
      @(negedge clock);
      csr.valid = 1'b1;
      csr.data  = value;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid = 1'b0;
      cur_dim   = (value == 0) ? 1 : ((value > MAX_EQ_DEF) ? MAX_EQ_DEF : int'(value));
   endtask

   function automatic logic [EQNO_W-1:0] pick_col();
      int hot;
      hot = (cur_dim < 6) ? cur_dim : 6;
      if ($urandom_range(1)) return EQNO_W'($urandom_range(1, hot));
      return EQNO_W'($urandom_range(1, cur_dim));
   endfunction

   // a read of the row store only where something was stored, else out of range
   task automatic read_row_safely();
      int idx;
      idx = $urandom_range(0, 8 * cur_dim + 8);
      if ($urandom_range(9) == 0) idx = $urandom_range(NNZ, 32767);
      if (idx < NNZ && !chk.row_written[idx]) idx = NNZ + $urandom_range(0, 16383);
      send_item(OP_READ_ROW, EQNO_W'($urandom), EQNO_W'($urandom), AMOUNT_W'($urandom),
                INDEX_W'(idx));
   endtask

   task automatic send_noise();
      case ($urandom_range(4))
         0: send_item(OP_SPARE_A + OP_W'($urandom_range(1)), EQNO_W'($urandom),
                      EQNO_W'($urandom), AMOUNT_W'($urandom), INDEX_W'($urandom));
         1: send_item(OP_INSERT, EQNO_W'($urandom), EQNO_W'($urandom), AMOUNT_W'($urandom),
                      INDEX_W'($urandom));
         2: send_item(OP_RESERVE, EQNO_W'($urandom), '0, AMOUNT_W'($urandom), '0);
         3: send_item(OP_READ_START, '0, '0, '0, INDEX_W'($urandom));
         default: send_item(OP_INSERT, ($urandom_range(1)) ? '0 : pick_col(),
                            '0, '0, '0);
      endcase
   endtask

   // one round: reserve, begin, inserts with reads and noise, compress, reads, a last insert
   task automatic run_round(input bit big_reserve, input bit long_hold);
      int nres, nins;
      nres = $urandom_range(3, 12);
      if (big_reserve) begin
         for (int i = 0; i < 132; i++)
            send_item(OP_RESERVE, pick_col(), '0, 7'd127, '0);
      end else begin
         for (int i = 0; i < nres; i++)
            send_item(OP_RESERVE, pick_col(), '0,
                      ($urandom_range(7) == 0) ? AMOUNT_W'($urandom_range(0, 127))
                                               : AMOUNT_W'($urandom_range(0, 10)), '0);
      end
      send_item(OP_BEGIN, '0, '0, '0, '0);
      if (long_hold) hold_asks++;
      nins = $urandom_range(30, 70);
      for (int i = 0; i < nins; i++) begin
         case ($urandom_range(9))
            0:       send_noise();
            1:       read_row_safely();
            2:       send_item(OP_READ_START, '0, '0, '0,
                               INDEX_W'($urandom_range(0, cur_dim + 1)));
            default: send_item(OP_INSERT, pick_col(),
                               EQNO_W'($urandom_range(1, cur_dim)), '0, '0);
         endcase
         if (i == nins / 2 && $urandom_range(2) == 0)
            send_item(OP_COMPRESS, '0, '0, '0, '0);
      end
      send_item(OP_COMPRESS, '0, '0, '0, '0);
      for (int i = 0; i < 8; i++) begin
         if ($urandom_range(1)) read_row_safely();
         else send_item(OP_READ_START, '0, '0, '0, INDEX_W'($urandom_range(0, cur_dim + 1)));
      end
      send_item(OP_INSERT, pick_col(), EQNO_W'($urandom_range(1, cur_dim)), '0, '0);
   endtask

   initial begin
      logic [NUMEQ_W-1:0] dims[10];
      int round;
      dims = '{11'd1024, 11'd0, 11'd2047, 11'd8, 11'd3, 11'd16, 11'd2, 11'd64, 11'd5, 11'd1};
      req.valid    = 1'b0;
      req.op       = OP_RESERVE;
      req.col_eqno = '0;
      req.row_eqno = '0;
      req.amount   = '0;
      req.index    = '0;
      csr.valid    = 1'b0;
      csr.data     = '0;
      send_idle    = 0;
      recv_stall   = 0;
      hold_asks    = 0;
      items_sent   = 0;
      cur_dim      = 1;
      reset        = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: dimension one, inactive and out-of-range cases, duplicates
      send_item(OP_RESERVE, 11'd0, '0, 7'd5, '0);
      send_item(OP_RESERVE, 11'd2, '0, 7'd5, '0);
      send_item(OP_RESERVE, 11'd1, '0, 7'd127, '0);
      send_item(OP_BEGIN, '0, '0, '0, '0);
      send_item(OP_INSERT, 11'd0, 11'd1, '0, '0);
      send_item(OP_INSERT, 11'd1, 11'd0, '0, '0);
      send_item(OP_INSERT, 11'd2, 11'd1, '0, '0);
      send_item(OP_INSERT, 11'd1, 11'd2, '0, '0);
      send_item(OP_INSERT, 11'd1, 11'd1, '0, '0);
      send_item(OP_INSERT, 11'd1, 11'd1, '0, '0);
      send_item(OP_READ_ROW, '0, '0, '0, 15'd0);
      // small dimension: a full column, compress, reads at the edges
      write_dim(11'd4);
      send_item(OP_RESERVE, 11'd4, '0, 7'd1, '0);
      send_item(OP_RESERVE, 11'd2, '0, 7'd64, '0);
      send_item(OP_BEGIN, '0, '0, '0, '0);
      send_item(OP_INSERT, 11'd4, 11'd3, '0, '0);
      send_item(OP_INSERT, 11'd4, 11'd2, '0, '0);
      send_item(OP_INSERT, 11'd2, 11'd4, '0, '0);
      send_item(OP_INSERT, 11'd2, 11'd1, '0, '0);
      send_item(OP_COMPRESS, '0, '0, '0, '0);
      send_item(OP_READ_START, '0, '0, '0, 15'd4);
      send_item(OP_READ_START, '0, '0, '0, 15'd5);
      send_item(OP_READ_ROW, '0, '0, '0, 15'd16384);
      send_item(OP_READ_ROW, '0, '0, '0, 15'd32767);
      send_item(OP_SPARE_A, 11'd2047, 11'd2047, 7'd127, 15'd32767);
      send_item(OP_SPARE_B, '0, '0, '0, '0);

      // random rounds over several dimensions and idling modes
      round = 0;
      while (items_sent < ITEM_TARGET) begin
         write_dim(dims[round % 10]);
         case (round % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 62; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 62; end
            default: begin send_idle = 14; recv_stall = 14; end
         endcase
         run_round(round == 0, round == 1 || round == 6);
         round++;
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** sparse_column_pattern_builder: PASSED **");
      end else begin
         $display("** sparse_column_pattern_builder: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/scpb_pkg.sv
rtl/scpb_channels.sv
rtl/scpb_ram.sv
rtl/sparse_column_pattern_builder.sv
verif/scpb_checker.sv
verif/tb.sv
